>>> rtl/core/infix_to_prefix_converter_defines.svh
// Assertion macros used by the port-level checker of the infix-to-prefix converter.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef INFIX_TO_PREFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_PREFIX_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define I2P_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define I2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/i2p_pkg.sv
// Types, character codes and helper functions of the infix-to-prefix converter.
// No dependencies; used by the controller, the datapath and the top level.
package i2p_pkg;

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNMATCH  = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    CLS_ALNUM,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP
  } cls_e;

  typedef enum logic [2:0] {
    SRC_CHAR,
    SRC_TOP,
    SRC_ERR_PAREN,
    SRC_ERR_OVF,
    SRC_END
  } emit_src_e;

  typedef struct packed {
    logic      load_in;
    logic      push;
    logic      pop;
    logic      emit;
    emit_src_e src;
  } ctrl_cmd_t;

  typedef struct packed {
    cls_e cls;
    logic count_zero;
    logic count_full;
    logic top_is_open;
    logic pop_cond;
    logic last;
    logic out_free;
  } dp_status_t;

  // Precedence ranks keep the order of the signed precedences; other characters rank 0.
  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    if (c == CH_CARET) begin
      p = 2'd3;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      p = 2'd2;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      p = 2'd1;
    end else begin
      p = 2'd0;
    end
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

>>> rtl/core/i2p_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the operator stack.
module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/i2p_ctrl.sv
// Controller state machine of the infix-to-prefix converter.
// Depends on i2p_pkg; drives the datapath by commands and reads its status.
module i2p_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2p_pkg::dp_status_t status_i,
  output i2p_pkg::ctrl_cmd_t  cmd_o
);
  import i2p_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_EWAIT = 3'd2;
  localparam logic [2:0] S_DWAIT = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] finish_state;

  // The stack read port is registered, so its data lags a count change; hence the wait states.
  assign finish_state = status_i.last ? S_DWAIT : S_IDLE;
  assign in_ready_o   = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{load_in: 1'b0, push: 1'b0, pop: 1'b0, emit: 1'b0, src: SRC_CHAR};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        unique case (status_i.cls)
          CLS_ALNUM: begin
            if (status_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.src  = SRC_CHAR;
              state_d    = finish_state;
            end
          end
          CLS_CLOSE: begin
            if (status_i.count_zero) begin
              if (status_i.out_free) begin
                cmd_o.emit = 1'b1;
                cmd_o.src  = SRC_ERR_PAREN;
                state_d    = finish_state;
              end
            end else if (status_i.top_is_open) begin
              cmd_o.pop = 1'b1;
              state_d   = finish_state;
            end else if (status_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.src  = SRC_TOP;
              cmd_o.pop  = 1'b1;
              state_d    = S_EWAIT;
            end
          end
          CLS_OPEN, CLS_OP: begin
            if (status_i.cls == CLS_OP && !status_i.count_zero && status_i.pop_cond) begin
              if (status_i.out_free) begin
                cmd_o.emit = 1'b1;
                cmd_o.src  = SRC_TOP;
                cmd_o.pop  = 1'b1;
                state_d    = S_EWAIT;
              end
            end else if (status_i.count_full) begin
              // A full stack drops the character and reports it.
              if (status_i.out_free) begin
                cmd_o.emit = 1'b1;
                cmd_o.src  = SRC_ERR_OVF;
                state_d    = finish_state;
              end
            end else begin
              cmd_o.push = 1'b1;
              state_d    = finish_state;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_EWAIT: state_d = S_EVAL;
      S_DWAIT: state_d = S_DRAIN;
      S_DRAIN: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!status_i.count_zero) begin
            cmd_o.src = SRC_TOP;
            cmd_o.pop = 1'b1;
            state_d   = S_DWAIT;
          end else begin
            cmd_o.src = SRC_END;
            state_d   = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/i2p_dp.sv
// Datapath of the infix-to-prefix converter: input latch, operator stack and output register.
// Depends on i2p_pkg and i2p_ram.
module i2p_dp #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          in_char_i,
  input  logic                in_last_i,
  input  i2p_pkg::ctrl_cmd_t  cmd_i,
  output i2p_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_char_o,
  output logic                out_has_o,
  output logic                out_end_o,
  output logic [1:0]          out_err_o
);
  import i2p_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [7:0]    char_q, char_d;
  logic          last_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] count_m1;
  logic [7:0]    top;
  logic          out_valid_q;
  logic [7:0]    out_char_q;
  logic          out_has_q;
  logic          out_end_q;
  logic [1:0]    out_err_q;
  logic          out_free;

  // Parentheses swap on entry, since the expression arrives reversed.
  always_comb begin
    if (in_char_i == CH_LPAREN) begin
      char_d = CH_RPAREN;
    end else if (in_char_i == CH_RPAREN) begin
      char_d = CH_LPAREN;
    end else begin
      char_d = in_char_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      char_q <= char_d;
      last_q <= in_last_i;
    end
  end

  assign count_m1 = count_q - CW'(1);

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // The read port is addressed at the current top entry; its registered data lags a count change.
  i2p_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(char_q),
    .raddr_i(count_m1[AW-1:0]),
    .rdata_o(top)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (is_alnum(char_q)) begin
      status_o.cls = CLS_ALNUM;
    end else if (char_q == CH_LPAREN) begin
      status_o.cls = CLS_OPEN;
    end else if (char_q == CH_RPAREN) begin
      status_o.cls = CLS_CLOSE;
    end else begin
      status_o.cls = CLS_OP;
    end
    status_o.count_zero  = (count_q == '0);
    status_o.count_full  = (count_q == CW'(STACK_DEPTH));
    status_o.top_is_open = (top == CH_LPAREN);
    status_o.pop_cond    = (char_q == CH_CARET) ? (prec_of(char_q) <= prec_of(top))
                                                : (prec_of(char_q) < prec_of(top));
    status_o.last        = last_q;
    status_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      unique case (cmd_i.src)
        SRC_CHAR: begin
          out_char_q <= char_q;
          out_has_q  <= 1'b1;
          out_end_q  <= 1'b0;
          out_err_q  <= ERR_NONE;
        end
        SRC_TOP: begin
          out_char_q <= top;
          out_has_q  <= 1'b1;
          out_end_q  <= 1'b0;
          out_err_q  <= ERR_NONE;
        end
        SRC_ERR_PAREN: begin
          out_char_q <= 8'h00;
          out_has_q  <= 1'b0;
          out_end_q  <= 1'b0;
          out_err_q  <= ERR_UNMATCH;
        end
        SRC_ERR_OVF: begin
          out_char_q <= 8'h00;
          out_has_q  <= 1'b0;
          out_end_q  <= 1'b0;
          out_err_q  <= ERR_OVERFLOW;
        end
        SRC_END: begin
          out_char_q <= 8'h00;
          out_has_q  <= 1'b0;
          out_end_q  <= 1'b1;
          out_err_q  <= ERR_NONE;
        end
        default: begin
          out_char_q <= 8'h00;
          out_has_q  <= 1'b0;
          out_end_q  <= 1'b0;
          out_err_q  <= ERR_NONE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_has_o   = out_has_q;
  assign out_end_o   = out_end_q;
  assign out_err_o   = out_err_q;

endmodule

>>> rtl/core/infix_to_prefix_converter.sv
// Infix-to-prefix converter top: controller i2p_ctrl and datapath i2p_dp; also needs i2p_pkg.
// A letter or digit is accepted in S_IDLE and emitted from S_EVAL once the output is free.
// Each stack pop that emits passes through S_EWAIT, due to the registered stack read port.
// A final character drains each stacked entry via S_DWAIT and S_DRAIN, then the end marker.
// The output register lets the next character be taken while a result waits.
// Reset clears the controller, the stack count and the output valid; no clearing pass.
module infix_to_prefix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] in_char
  input  logic       s_axis_tlast,  // is_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_char
  output logic [2:0] m_axis_tuser,  // [0] has_char, [2:1] error_code
  output logic       m_axis_tlast   // end_of_expr
);
  import i2p_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       out_has;
  logic [1:0] out_err;

  i2p_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  i2p_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_char_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_char_o (m_axis_tdata),
    .out_has_o  (out_has),
    .out_end_o  (m_axis_tlast),
    .out_err_o  (out_err)
  );

  assign m_axis_tuser = {out_err, out_has};

endmodule

>>> rtl/core/i2p_checker.sv
// Port-level checker for the infix-to-prefix converter, bound to the top level.
// Depends on infix_to_prefix_converter_defines.svh for its assertion macros and on i2p_pkg.
`include "infix_to_prefix_converter_defines.svh"

module i2p_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);
  import i2p_pkg::*;

  logic        in_acc;
  logic        out_stall;
  logic        end_seen;
  logic        err_seen;
  logic        marker_seen;
  logic        out_has;
  logic        out_flagged;
  logic [1:0]  out_err;
  logic [11:0] out_word;

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign out_has     = m_axis_tuser[0];
  assign out_err     = m_axis_tuser[2:1];
  assign out_flagged = out_has || m_axis_tlast;
  assign out_word    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign end_seen    = m_axis_tvalid && m_axis_tlast;
  assign err_seen    = m_axis_tvalid && (out_err != ERR_NONE);
  assign marker_seen = m_axis_tvalid && !out_has;

  // A stalled result transaction holds its payload.
  `I2P_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "result not held")

  // An accepted character is evaluated before the next one can be accepted.
  `I2P_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready, "input accepted back to back")

  `I2P_ASSERT_NOW(a_end_bare, end_seen, !out_has && out_err == ERR_NONE, "bad end marker")

  `I2P_ASSERT_NOW(a_err_bare, err_seen, !out_flagged && out_err <= ERR_OVERFLOW, "bad error marker")

  `I2P_ASSERT_NOW(a_marker_zero, marker_seen, m_axis_tdata == 8'h00, "marker has a character")

endmodule

bind infix_to_prefix_converter i2p_checker u_i2p_checker (.*);

>>> tb/infix_to_prefix_checker.sv
// Checker for the infix-to-prefix converter: mirrors the operator stack, predicts
// every output transaction and compares it with what the block delivers.
// Depends on i2p_pkg for the character and error codes.
`timescale 1ns / 100ps

module infix_to_prefix_checker #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] in_char
  input  logic       s_axis_tlast,  // is_last
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,  // [7:0] out_char
  input  logic [2:0] m_axis_tuser,  // [0] has_char, [2:1] error_code
  input  logic       m_axis_tlast,  // end_of_expr
  output int         fail_count_o,
  output int         pending_o,
  output int         results_seen_o,
  output int         unmatched_seen_o,
  output int         overflow_seen_o
);
  import i2p_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       end_of_expr;
    logic [1:0] err;
  } prefix_out_t;

  prefix_out_t prefix_q[$];
  logic [7:0]  stack_mirror [STACK_DEPTH];
  int          stack_fill;
  int          misses;
  int          seen;
  int          n_unmatched;
  int          n_overflow;

  function automatic int rank_of(input logic [7:0] c);
    case (c)
      CH_CARET:          return 3;
      CH_STAR, CH_SLASH: return 2;
      CH_PLUS, CH_MINUS: return 1;
      default:           return -1;
    endcase
  endfunction

  function automatic bit is_name_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void expect_out(input logic [7:0] ch, input logic has,
                                     input logic eoe, input logic [1:0] err);
    prefix_out_t r;
    r.ch          = ch;
    r.has_char    = has;
    r.end_of_expr = eoe;
    r.err         = err;
    prefix_q.push_back(r);
  endfunction

  function automatic logic [7:0] pop_top();
    stack_fill--;
    return stack_mirror[stack_fill];
  endfunction

  // A push onto a full stack drops the character and raises an overflow marker.
  function automatic void push_op(input logic [7:0] c);
    if (stack_fill >= STACK_DEPTH) begin
      expect_out(8'h00, 1'b0, 1'b0, ERR_OVERFLOW);
    end else begin
      stack_mirror[stack_fill] = c;
      stack_fill++;
    end
  endfunction

  function automatic void convert_char(input logic [7:0] raw, input logic last);
    logic [7:0] c;
    logic [7:0] top;
    int         p;
    bit         found;
    bit         go;
    c = raw;
    // The feeder runs backwards, so the parentheses trade roles.
    if (raw == CH_LPAREN) begin
      c = CH_RPAREN;
    end else if (raw == CH_RPAREN) begin
      c = CH_LPAREN;
    end
    if (is_name_char(c)) begin
      expect_out(c, 1'b1, 1'b0, ERR_NONE);
    end else if (c == CH_LPAREN) begin
      push_op(c);
    end else if (c == CH_RPAREN) begin
      found = 1'b0;
      while (stack_fill > 0 && !found) begin
        top = pop_top();
        if (top == CH_LPAREN) begin
          found = 1'b1;
        end else begin
          expect_out(top, 1'b1, 1'b0, ERR_NONE);
        end
      end
      if (!found) begin
        expect_out(8'h00, 1'b0, 1'b0, ERR_UNMATCH);
      end
    end else begin
      p  = rank_of(c);
      go = 1'b1;
      while (stack_fill > 0 && go) begin
        if (c == CH_CARET) begin
          go = (p <= rank_of(stack_mirror[stack_fill - 1]));
        end else begin
          go = (p < rank_of(stack_mirror[stack_fill - 1]));
        end
        if (go) begin
          expect_out(pop_top(), 1'b1, 1'b0, ERR_NONE);
        end
      end
      push_op(c);
    end
    if (last) begin
      while (stack_fill > 0) begin
        expect_out(pop_top(), 1'b1, 1'b0, ERR_NONE);
      end
      expect_out(8'h00, 1'b0, 1'b1, ERR_NONE);
    end
  endfunction

  function automatic void report_miss(input string what, input prefix_out_t want,
                                      input prefix_out_t got);
    misses++;
    if (misses <= 10) begin
      $display("%0t checker: %s: expected ch/has/end/err=%02h/%0b/%0b/%0d",
               $time, what, want.ch, want.has_char, want.end_of_expr, want.err);
      $display("%0t checker: %s: got      ch/has/end/err=%02h/%0b/%0b/%0d",
               $time, what, got.ch, got.has_char, got.end_of_expr, got.err);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    prefix_out_t got;
    prefix_out_t want;
    if (!rst_ni) begin
      prefix_q.delete();
      stack_fill  = 0;
      misses      = 0;
      seen        = 0;
      n_unmatched = 0;
      n_overflow  = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        convert_char(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.ch          = m_axis_tdata;
        got.has_char    = m_axis_tuser[0];
        got.err         = m_axis_tuser[2:1];
        got.end_of_expr = m_axis_tlast;
        seen++;
        if (prefix_q.size() == 0) begin
          want = '0;
          report_miss("transaction with nothing expected", want, got);
        end else begin
          want = prefix_q.pop_front();
          if (want.err == ERR_UNMATCH) begin
            n_unmatched++;
          end
          if (want.err == ERR_OVERFLOW) begin
            n_overflow++;
          end
          if (got.ch !== want.ch || got.has_char !== want.has_char ||
              got.end_of_expr !== want.end_of_expr || got.err !== want.err) begin
            report_miss("mismatch", want, got);
          end
        end
      end
    end
    fail_count_o     <= misses;
    pending_o        <= prefix_q.size();
    results_seen_o   <= seen;
    unmatched_seen_o <= n_unmatched;
    overflow_seen_o  <= n_overflow;
  end

endmodule

>>> tb/tb.sv
// Testbench top for the infix-to-prefix converter: clock, reset, expression stimulus
// and ready pacing. Depends on i2p_pkg and on infix_to_prefix_checker for the verdict.
`timescale 1ns / 100ps

module tb;
  import i2p_pkg::*;

  localparam int STACK_DEPTH = 32;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_char
  logic       s_axis_tlast;   // is_last
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_char
  logic [2:0] m_axis_tuser;   // [0] has_char, [2:1] error_code
  logic       m_axis_tlast;   // end_of_expr

  int         fail_count;
  int         pending;
  int         results_seen;
  int         unmatched_seen;
  int         overflow_seen;

  bit         quiet = 1'b0;
  int         chars_sent = 0;
  int         exprs_sent = 0;
  logic [7:0] infix_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  infix_to_prefix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  infix_to_prefix_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .results_seen_o   (results_seen),
    .unmatched_seen_o (unmatched_seen),
    .overflow_seen_o  (overflow_seen)
  );

  function automatic logic [7:0] alnum_pick();
    case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] op_pick();
    case ($urandom_range(0, 4))
      0:       return CH_CARET;
      1:       return CH_STAR;
      2:       return CH_SLASH;
      3:       return CH_PLUS;
      default: return CH_MINUS;
    endcase
  endfunction

  // Appends a well-formed infix expression with nesting up to the given depth.
  function automatic void grow_expr(input int depth);
    int terms;
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) begin
        infix_q.push_back(op_pick());
      end
      if (depth > 0 && $urandom_range(0, 2) == 0) begin
        infix_q.push_back(CH_LPAREN);
        grow_expr(depth - 1);
        infix_q.push_back(CH_RPAREN);
      end else begin
        infix_q.push_back(alnum_pick());
      end
    end
  endfunction

  // Each call starts at the rising edge where the previous transaction completed.
  task automatic send_char(input logic [7:0] c, input logic last, input bit calm);
    int gap;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chars_sent++;
  endtask

  // The expression goes in from its last character to its first.
  task automatic feed_infix();
    bit calm;
    calm = ($urandom_range(0, 3) == 0);
    for (int i = infix_q.size() - 1; i >= 0; i--) begin
      send_char(infix_q[i], i == 0, calm);
    end
    exprs_sent++;
  endtask

  task automatic feed_text(input string t);
    infix_q.delete();
    for (int i = 0; i < t.len(); i++) begin
      infix_q.push_back(t[i]);
    end
    feed_infix();
  endtask

  initial begin : sink_pacing
    int run;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      run = $urandom_range(1, 16);
      repeat (run) @(posedge clk_i);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        run = $urandom_range(1, 16);
        repeat (run) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int pick;
    int fill;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    feed_text("z");
    feed_text("A^0^9");          // carets pop their equals
    feed_text("(a+b)*c/d-Z");
    feed_text("x(");             // closing paren with an empty stack
    feed_text("a~b");            // a character with no precedence
    infix_q.delete();
    infix_q.push_back(8'hFF);
    infix_q.push_back(8'h00);
    feed_infix();

    while (chars_sent < 200) begin
      if (chars_sent >= 170) begin
        quiet = 1'b1;
      end
      infix_q.delete();
      pick = $urandom_range(0, 99);
      if (exprs_sent == 8 || exprs_sent == 14) begin
        // Every character but the first pushes; the first run always overflows the stack.
        fill = (exprs_sent == 8) ? $urandom_range(33, 36) : $urandom_range(28, 36);
        infix_q.push_back($urandom_range(0, 1) ? alnum_pick() : op_pick());
        repeat (fill) begin
          case ($urandom_range(0, 2))
            0:       infix_q.push_back(CH_RPAREN);
            1:       infix_q.push_back(CH_PLUS);
            default: infix_q.push_back(CH_MINUS);
          endcase
        end
      end else if (pick < 70) begin
        grow_expr(2);
      end else if (pick < 85) begin
        grow_expr(1);
        case ($urandom_range(0, 2))
          0:       infix_q.insert($urandom_range(0, infix_q.size()), CH_LPAREN);
          1:       infix_q.insert($urandom_range(0, infix_q.size()), CH_RPAREN);
          default: infix_q.insert($urandom_range(0, infix_q.size()), op_pick());
        endcase
      end else begin
        repeat ($urandom_range(1, 6)) infix_q.push_back(8'($urandom_range(0, 255)));
      end
      feed_infix();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("Fed %0d characters in %0d expressions; %0d output transactions checked.",
             chars_sent, exprs_sent, results_seen);
    $display("Error markers seen: %0d unmatched parenthesis, %0d stack overflow.",
             unmatched_seen, overflow_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[infix_to_prefix_converter] OK");
    end else begin
      $display("[infix_to_prefix_converter] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[infix_to_prefix_converter] ERROR");
    $finish;
  end

endmodule
